[hdl/ecbm_pkg.sv]
// ---------------------------------------------------------------------------
// ecbm_pkg: shared types, constants and fixed-point helpers
// Item kinds, CORDIC constants, rounding and saturation functions used by the
// camera basis and motion block.
// ---------------------------------------------------------------------------
package ecbm_pkg;

    localparam int VEC_FRAC_BITS_DEF = 14;
    localparam int POS_FRAC_BITS_DEF = 16;

    localparam int ANG_W = 17;
    localparam int Q30_W = 34;   // Q30 values with headroom
    localparam int Z_W   = 26;   // CORDIC angle, 1/65536 degree
    localparam int CORDIC_STEPS = 16;

    typedef logic signed [Q30_W-1:0] t_q30;
    typedef logic signed [Z_W-1:0]   t_zang;

    // item kinds
    localparam logic [2:0] K_ORIENT = 3'd0;
    localparam logic [2:0] K_FWD    = 3'd1;
    localparam logic [2:0] K_BACK   = 3'd2;
    localparam logic [2:0] K_LEFT   = 3'd3;
    localparam logic [2:0] K_RIGHT  = 3'd4;
    localparam logic [2:0] K_UP     = 3'd5;
    localparam logic [2:0] K_DOWN   = 3'd6;
    localparam logic [2:0] K_HOME   = 3'd7;

    localparam logic signed [ANG_W:0] ONE_TURN  = 18'sd46080;
    localparam logic signed [ANG_W:0] HALF_TURN = 18'sd23040;
    localparam t_zang DEG_90  = 26'sd5898240;
    localparam t_zang DEG_180 = 26'sd11796480;
    localparam t_q30  CORDIC_GAIN = 34'sd652032874;

    function automatic t_zang atan_lut(input logic [3:0] i);
        t_zang r;
        unique case (i)
            4'd0:  r = 26'sd2949120;
            4'd1:  r = 26'sd1740967;
            4'd2:  r = 26'sd919879;
            4'd3:  r = 26'sd466945;
            4'd4:  r = 26'sd234379;
            4'd5:  r = 26'sd117304;
            4'd6:  r = 26'sd58666;
            4'd7:  r = 26'sd29335;
            4'd8:  r = 26'sd14668;
            4'd9:  r = 26'sd7334;
            4'd10: r = 26'sd3667;
            4'd11: r = 26'sd1833;
            4'd12: r = 26'sd917;
            4'd13: r = 26'sd458;
            4'd14: r = 26'sd229;
            4'd15: r = 26'sd115;
            default: r = '0;
        endcase
        return r;
    endfunction

    // scale by 2^-s, round half up; exact left shift when s <= 0
    function automatic logic signed [63:0] rsc(input logic signed [63:0] v, input int s);
        logic signed [63:0] r;
        if (s <= 0) begin
            r = v <<< (-s);
        end else begin
            r = (v + (64'sd1 <<< (s - 1))) >>> s;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -64'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[hdl/ecbm_cordic.sv]
// ---------------------------------------------------------------------------
// ecbm_cordic: iterative sine/cosine unit
// Reduces a 1/128 degree angle to [-90,90] degrees and runs 16 rotation
// steps, one per cycle. Results are Q30.
// ---------------------------------------------------------------------------
module ecbm_cordic
    import ecbm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [ANG_W-1:0] i_ang,
    output logic                    o_done,
    output t_q30                    o_sin,
    output t_q30                    o_cos
);

    logic               r_busy;
    logic               r_done;
    logic [3:0]         r_it;
    logic               r_neg;
    t_q30               r_x, r_y;
    t_zang              r_z;

    logic signed [ANG_W:0] s_a0, s_a1;
    t_zang              s_z0, s_zf;
    logic               s_negf;
    t_q30               s_xs, s_ys;

    always_comb begin
        s_a0 = (ANG_W+1)'(i_ang);
        if (s_a0 >= HALF_TURN) begin
            s_a1 = s_a0 - ONE_TURN;
        end else if (s_a0 < -HALF_TURN) begin
            s_a1 = s_a0 + ONE_TURN;
        end else begin
            s_a1 = s_a0;
        end
        s_z0   = Z_W'(s_a1) <<< 9;
        s_negf = 1'b0;
        s_zf   = s_z0;
        if (s_z0 > DEG_90) begin
            s_zf   = s_z0 - DEG_180;
            s_negf = 1'b1;
        end else if (s_z0 < -DEG_90) begin
            s_zf   = s_z0 + DEG_180;
            s_negf = 1'b1;
        end
        s_xs = r_x >>> r_it;
        s_ys = r_y >>> r_it;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_it   <= '0;
        end else begin
            r_done <= r_busy && (r_it == 4'(CORDIC_STEPS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_it   <= '0;
            end else if (r_busy) begin
                r_it <= r_it + 4'd1;
                if (r_it == 4'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= CORDIC_GAIN;
            r_y   <= '0;
            r_z   <= s_zf;
            r_neg <= s_negf;
        end else if (r_busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - s_ys;
                r_y <= r_y + s_xs;
                r_z <= r_z - atan_lut(r_it);
            end else begin
                r_x <= r_x + s_ys;
                r_y <= r_y - s_xs;
                r_z <= r_z + atan_lut(r_it);
            end
        end
    end

    assign o_done = r_done;
    assign o_sin  = r_neg ? -r_y : r_y;
    assign o_cos  = r_neg ? -r_x : r_x;

endmodule

[hdl/ecbm_mul.sv]
// ---------------------------------------------------------------------------
// ecbm_mul: shared registered multiplier
// One signed 32x32 product per cycle, registered at the output.
// ---------------------------------------------------------------------------
module ecbm_mul
    import ecbm_pkg::*;
(
    input  logic               i_clk,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [63:0] o_p
);

    logic signed [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

[hdl/euler_camera_basis_and_motion.sv]
// ---------------------------------------------------------------------------
// euler_camera_basis_and_motion: camera orientation and motion unit
// Orient items build forward/up/right vectors from yaw, pitch and roll; move
// items shift a saturating Q16.16 position. Every item returns eye, center, up.
// ---------------------------------------------------------------------------
// One item at a time; s_axis_tready is high only while idle. An orient item
// does three 16-step CORDIC runs (each after a load state), then nine products
// on the shared multiplier, each read from its output register, a vector state,
// six cross products made the same way, and an output state. Moves make three
// products; up/down/home go straight to the output state. The result is held
// on m_axis until taken, then the block is ready again the cycle after.
module euler_camera_basis_and_motion
    import ecbm_pkg::*;
#(
    parameter int VEC_FRAC_BITS = VEC_FRAC_BITS_DEF,
    parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
)
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // yaw_deg[16:0], pitch_deg[33:17], roll_deg[50:34], step_time[66:51], zero fill
    input  logic [71:0]  s_axis_tdata,
    // kind[2:0]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // eye_x, eye_y, eye_z, center_x, center_y, center_z (32 each), upv_x, upv_y,
    // upv_z (16 each), from bit 0 up
    output logic [239:0] m_axis_tdata
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLOAD = 4'd1;
    localparam logic [3:0] ST_CRUN  = 4'd2;
    localparam logic [3:0] ST_MUL   = 4'd3;
    localparam logic [3:0] ST_VEC   = 4'd4;
    localparam logic [3:0] ST_CROSS = 4'd5;
    localparam logic [3:0] ST_MOVE  = 4'd6;
    localparam logic [3:0] ST_OUT   = 4'd7;
    localparam logic [3:0] ST_HOLD  = 4'd8;

    localparam int MOVE_SH = 16 + VEC_FRAC_BITS - POS_FRAC_BITS;
    localparam int DY_SH   = 16 - POS_FRAC_BITS;
    localparam int CTR_SH  = VEC_FRAC_BITS - POS_FRAC_BITS;
    localparam int VEC_SH  = 30 - VEC_FRAC_BITS;
    localparam logic signed [31:0] POS_SIX = 32'sd6 <<< POS_FRAC_BITS;

    logic [3:0]  r_state;
    logic [1:0]  r_ang;
    logic [3:0]  r_op;
    logic        r_ph;
    logic [2:0]  r_kind;
    logic signed [ANG_W-1:0] r_yaw, r_pitch, r_roll;
    logic [15:0] r_dt;

    t_q30 r_sy, r_cy, r_sp, r_cp, r_sr, r_cr;
    t_q30 r_t0, r_t1, r_t2, r_t3, r_t4, r_t5, r_t6;
    logic signed [33:0] r_acc;

    logic signed [15:0] r_fx, r_fy, r_fz, r_ux, r_uy, r_uz, r_rx, r_ry, r_rz;
    logic signed [31:0] r_px, r_py, r_pz;

    logic         r_mvalid;
    logic [239:0] r_mdata;

    logic               s_acc_in;
    logic               s_cstart;
    logic signed [ANG_W-1:0] s_cang;
    logic               s_cdone;
    t_q30               s_csin, s_ccos;
    logic signed [31:0] s_ma, s_mb;
    logic signed [63:0] s_mp;
    logic signed [63:0] s_q;
    logic signed [63:0] s_dy;
    logic signed [15:0] s_mv;
    logic signed [31:0] s_mpos;
    logic signed [31:0] s_mnew;
    logic signed [63:0] s_md;
    logic signed [15:0] s_xt;

    assign s_acc_in      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;

    assign s_cstart = (r_state == ST_CLOAD);

    always_comb begin
        unique case (r_ang)
            2'd0:    s_cang = r_yaw;
            2'd1:    s_cang = r_pitch;
            default: s_cang = r_roll;
        endcase
    end

    ecbm_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_cstart),
        .i_ang   (s_cang),
        .o_done  (s_cdone),
        .o_sin   (s_csin),
        .o_cos   (s_ccos)
    );

    // operand selection for the shared multiplier
    always_comb begin
        s_ma = '0;
        s_mb = '0;
        s_mv = '0;
        unique case (r_state)
            ST_MUL: begin
                unique case (r_op)
                    4'd0:    begin s_ma = r_sy[31:0]; s_mb = r_cp[31:0]; end
                    4'd1:    begin s_ma = r_cp[31:0]; s_mb = r_cy[31:0]; end
                    4'd2:    begin s_ma = r_cy[31:0]; s_mb = r_sr[31:0]; end
                    4'd3:    begin s_ma = r_sy[31:0]; s_mb = r_sp[31:0]; end
                    4'd4:    begin s_ma = r_t3[31:0]; s_mb = r_cr[31:0]; end
                    4'd5:    begin s_ma = r_cp[31:0]; s_mb = r_cr[31:0]; end
                    4'd6:    begin s_ma = r_sy[31:0]; s_mb = r_sr[31:0]; end
                    4'd7:    begin s_ma = r_sp[31:0]; s_mb = r_cr[31:0]; end
                    default: begin s_ma = r_t6[31:0]; s_mb = r_cy[31:0]; end
                endcase
            end
            ST_CROSS: begin
                unique case (r_op)
                    4'd0:    begin s_ma = 32'(r_fy); s_mb = 32'(r_uz); end
                    4'd1:    begin s_ma = 32'(r_fz); s_mb = 32'(r_uy); end
                    4'd2:    begin s_ma = 32'(r_fz); s_mb = 32'(r_ux); end
                    4'd3:    begin s_ma = 32'(r_fx); s_mb = 32'(r_uz); end
                    4'd4:    begin s_ma = 32'(r_fx); s_mb = 32'(r_uy); end
                    default: begin s_ma = 32'(r_fy); s_mb = 32'(r_ux); end
                endcase
            end
            ST_MOVE: begin
                priority if (r_kind == K_FWD || r_kind == K_BACK) begin
                    unique case (r_op)
                        4'd0:    s_mv = r_fx;
                        4'd1:    s_mv = r_fy;
                        default: s_mv = r_fz;
                    endcase
                end else begin
                    unique case (r_op)
                        4'd0:    s_mv = r_rx;
                        4'd1:    s_mv = r_ry;
                        default: s_mv = r_rz;
                    endcase
                end
                s_ma = 32'(s_mv);
                s_mb = signed'({16'd0, r_dt});
            end
            default: begin
                s_ma = '0;
            end
        endcase
    end

    ecbm_mul u_mul (
        .i_clk (i_clk),
        .i_a   (s_ma),
        .i_b   (s_mb),
        .o_p   (s_mp)
    );

    always_comb begin
        s_q  = rsc(s_mp, 30);
        s_dy = rsc(64'(signed'({1'b0, s_axis_tdata[66:51]})), DY_SH);
        s_xt = sat16(rsc(64'(r_acc) - s_mp, VEC_FRAC_BITS));
        unique case (r_op)
            4'd0:    s_mpos = r_px;
            4'd1:    s_mpos = r_py;
            default: s_mpos = r_pz;
        endcase
        s_md = rsc(s_mp, MOVE_SH);
        if (r_kind == K_BACK || r_kind == K_LEFT) begin
            s_mnew = sat32(64'(s_mpos) - s_md);
        end else begin
            s_mnew = sat32(64'(s_mpos) + s_md);
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ang    <= '0;
            r_op     <= '0;
            r_ph     <= 1'b0;
            r_mvalid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_ang <= '0;
                    r_op  <= '0;
                    r_ph  <= 1'b0;
                    if (s_acc_in) begin
                        priority case (s_axis_tuser)
                            K_ORIENT:                         r_state <= ST_CLOAD;
                            K_FWD, K_BACK, K_LEFT, K_RIGHT:   r_state <= ST_MOVE;
                            default:                          r_state <= ST_OUT;
                        endcase
                    end
                end
                ST_CLOAD: r_state <= ST_CRUN;
                ST_CRUN: begin
                    if (s_cdone) begin
                        r_ang <= r_ang + 2'd1;
                        r_state <= (r_ang == 2'd2) ? ST_MUL : ST_CLOAD;
                    end
                end
                ST_MUL: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_op <= r_op + 4'd1;
                        if (r_op == 4'd8) begin
                            r_state <= ST_VEC;
                        end
                    end
                end
                ST_VEC: begin
                    r_op    <= '0;
                    r_state <= ST_CROSS;
                end
                ST_CROSS: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_op <= r_op + 4'd1;
                        if (r_op == 4'd5) begin
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_MOVE: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_op <= r_op + 4'd1;
                        if (r_op == 4'd2) begin
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_OUT: begin
                    r_mvalid <= 1'b1;
                    r_state  <= ST_HOLD;
                end
                ST_HOLD: begin
                    if (m_axis_tready) begin
                        r_mvalid <= 1'b0;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // vector and position state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= '0;
            r_py <= '0;
            r_pz <= POS_SIX;
            r_fx <= '0; r_fy <= '0; r_fz <= '0;
            r_ux <= '0; r_uy <= '0; r_uz <= '0;
            r_rx <= '0; r_ry <= '0; r_rz <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (s_acc_in) begin
                        if (s_axis_tuser == K_UP) begin
                            r_py <= sat32(64'(r_py) + s_dy);
                        end else if (s_axis_tuser == K_DOWN) begin
                            r_py <= sat32(64'(r_py) - s_dy);
                        end else if (s_axis_tuser == K_HOME) begin
                            r_px <= '0;
                            r_py <= '0;
                            r_pz <= POS_SIX;
                        end
                    end
                end
                ST_VEC: begin
                    r_fx <= sat16(rsc(64'(r_t0), VEC_SH));
                    r_fy <= sat16(rsc(64'(r_sp), VEC_SH));
                    r_fz <= sat16(rsc(-64'(r_t1), VEC_SH));
                    r_ux <= sat16(rsc(-64'(r_t2) - 64'(r_t3), VEC_SH));
                    r_uy <= sat16(rsc(64'(r_t4), VEC_SH));
                    r_uz <= sat16(rsc(64'(r_t6) - 64'(r_t5), VEC_SH));
                end
                ST_CROSS: begin
                    if (r_ph && r_op[0]) begin
                        unique case (r_op[2:1])
                            2'd0:    r_rx <= s_xt;
                            2'd1:    r_ry <= s_xt;
                            default: r_rz <= s_xt;
                        endcase
                    end
                end
                ST_MOVE: begin
                    if (r_ph) begin
                        unique case (r_op)
                            4'd0:    r_px <= s_mnew;
                            4'd1:    r_py <= s_mnew;
                            default: r_pz <= s_mnew;
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_acc_in) begin
            r_kind  <= s_axis_tuser;
            r_yaw   <= s_axis_tdata[16:0];
            r_pitch <= s_axis_tdata[33:17];
            r_roll  <= s_axis_tdata[50:34];
            r_dt    <= s_axis_tdata[66:51];
        end
        if (r_state == ST_CRUN && s_cdone) begin
            unique case (r_ang)
                2'd0:    begin r_sy <= s_csin; r_cy <= s_ccos; end
                2'd1:    begin r_sp <= s_csin; r_cp <= s_ccos; end
                default: begin r_sr <= s_csin; r_cr <= s_ccos; end
            endcase
        end
        if (r_state == ST_MUL && r_ph) begin
            unique case (r_op)
                4'd0:    r_t0 <= s_q[Q30_W-1:0];
                4'd1:    r_t1 <= s_q[Q30_W-1:0];
                4'd2:    r_t2 <= s_q[Q30_W-1:0];
                4'd3:    r_t3 <= s_q[Q30_W-1:0];
                4'd4:    r_t3 <= s_q[Q30_W-1:0];
                4'd5:    r_t4 <= s_q[Q30_W-1:0];
                4'd6:    r_t5 <= s_q[Q30_W-1:0];
                4'd7:    r_t6 <= s_q[Q30_W-1:0];
                default: r_t6 <= s_q[Q30_W-1:0];
            endcase
        end
        if (r_state == ST_CROSS && r_ph && !r_op[0]) begin
            r_acc <= s_mp[33:0];
        end
        if (r_state == ST_OUT) begin
            r_mdata <= {r_uz, r_uy, r_ux,
                        sat32(64'(r_pz) + rsc(64'(r_fz), CTR_SH)),
                        sat32(64'(r_py) + rsc(64'(r_fy), CTR_SH)),
                        sat32(64'(r_px) + rsc(64'(r_fx), CTR_SH)),
                        r_pz, r_py, r_px};
        end
    end

`ifndef SYNTHESIS
    a_idle_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !m_axis_tvalid)
        else $error("result pending while idle");

    a_orient_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc_in && s_axis_tuser == K_ORIENT) |=> (r_state == ST_CLOAD))
        else $error("orient item did not start CORDIC");

    a_ang_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLOAD || r_state == ST_CRUN) |-> (r_ang != 2'd3))
        else $error("angle index out of range");

    a_home_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc_in && s_axis_tuser == K_HOME) |=>
        (r_px == 32'sd0 && r_py == 32'sd0 && r_pz == POS_SIX))
        else $error("home did not reset position");
`endif

endmodule
